@@ rtl/core/pear_pkg.sv @@
package pear_pkg;

	localparam int NUM_BUTTONS_DEF = 5;
	localparam int HELD_W = 5;
	localparam int VAL_W = 16;
	localparam int CODE_W = 10;
	localparam int BTN_IDX_W = 3;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [1:0] KIND_REL = 2'd0;
	localparam logic [1:0] KIND_KEY = 2'd2;

	localparam logic [CODE_W-1:0] CODE_X = 10'd0;
	localparam logic [CODE_W-1:0] CODE_Y = 10'd1;
	localparam logic [CODE_W-1:0] CODE_HWHEEL = 10'd6;
	localparam logic [CODE_W-1:0] CODE_WHEEL = 10'd8;
	localparam logic [1:0] CODE_BTN_PAGE = 2'b01;

	localparam logic [2:0] REG_SWAP_AXES = 3'd0;
	localparam logic [2:0] REG_INVERT_X = 3'd1;
	localparam logic [2:0] REG_INVERT_Y = 3'd2;
	localparam logic [2:0] REG_SCALE_MUL = 3'd3;
	localparam logic [2:0] REG_SCALE_DIV = 3'd4;

	typedef enum logic [2:0] {
		DEST_NONE,
		DEST_X,
		DEST_Y,
		DEST_HWHEEL,
		DEST_WHEEL,
		DEST_BUTTON
	} dest_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [CODE_W-1:0] event_code;
		logic signed [VAL_W-1:0] event_value;
		logic sync_mark;
		logic from_device;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] move_x;
		logic signed [VAL_W-1:0] move_y;
		logic signed [VAL_W-1:0] scroll_x;
		logic signed [VAL_W-1:0] scroll_y;
		logic [HELD_W-1:0] held_buttons;
	} out_item_t;

	typedef struct packed {
		dest_t dest;
		logic [BTN_IDX_W-1:0] btn_idx;
		logic sync;
		logic dev;
		logic neg;
		logic [VAL_W-1:0] value;
	} q_entry_t;

	typedef struct packed {
		logic swap_axes;
		logic invert_x;
		logic invert_y;
		logic [VAL_W-1:0] scale_mul;
		logic [VAL_W-1:0] scale_div;
	} cfg_t;

	typedef struct packed {
		logic pop;
		logic load;
	} bk_stat_t;

endpackage

@@ rtl/core/pointer_event_report_aggregator_unit.sv @@
// A device transaction passes through the back end in steps: a load, a multiply,
// the radix-4 divider and an update of the frame state.
// Any other transaction goes from the load straight to the frame state update.
// A sync update, which makes the report valid, waits while an earlier report is stalled.
// A two-entry queue accepts new transactions while the back end is busy.
// Reset clears all sums, button state and the queue, and sets scale_mul and scale_div to 1.
module pointer_event_report_aggregator_unit #(
	parameter int NUM_BUTTONS = pear_pkg::NUM_BUTTONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  pear_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output pear_pkg::out_item_t               out_data,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pear_pkg::ADDR_W-1:0]       paddr,
	input  logic [pear_pkg::DATA_W-1:0]       pwdata,
	output logic [pear_pkg::DATA_W-1:0]       prdata,
	output logic                              pready
);

	pear_pkg::cfg_t cfg_q;
	logic [2:0] reg_idx;
	logic q_full;
	logic q_valid;
	logic push;
	pear_pkg::q_entry_t front_entry;
	pear_pkg::q_entry_t q_entry;
	pear_pkg::bk_stat_t bk_stat;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.swap_axes <= 1'b0;
			cfg_q.invert_x <= 1'b0;
			cfg_q.invert_y <= 1'b0;
			cfg_q.scale_mul <= pear_pkg::VAL_W'(1);
			cfg_q.scale_div <= pear_pkg::VAL_W'(1);
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				pear_pkg::REG_SWAP_AXES: cfg_q.swap_axes <= pwdata[0];
				pear_pkg::REG_INVERT_X: cfg_q.invert_x <= pwdata[0];
				pear_pkg::REG_INVERT_Y: cfg_q.invert_y <= pwdata[0];
				pear_pkg::REG_SCALE_MUL: cfg_q.scale_mul <= pwdata[pear_pkg::VAL_W-1:0];
				pear_pkg::REG_SCALE_DIV: cfg_q.scale_div <= pwdata[pear_pkg::VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			pear_pkg::REG_SWAP_AXES: prdata = pear_pkg::DATA_W'(cfg_q.swap_axes);
			pear_pkg::REG_INVERT_X: prdata = pear_pkg::DATA_W'(cfg_q.invert_x);
			pear_pkg::REG_INVERT_Y: prdata = pear_pkg::DATA_W'(cfg_q.invert_y);
			pear_pkg::REG_SCALE_MUL: prdata = pear_pkg::DATA_W'(cfg_q.scale_mul);
			pear_pkg::REG_SCALE_DIV: prdata = pear_pkg::DATA_W'(cfg_q.scale_div);
			default: prdata = '0;
		endcase
	end

	pear_front #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_front (
		.cfg     (cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data (in_data),
		.q_full  (q_full),
		.push    (push),
		.entry   (front_entry)
	);

	pear_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.entry_in (front_entry),
		.full     (q_full),
		.pop      (bk_stat.pop),
		.valid    (q_valid),
		.entry_out(q_entry)
	);

	pear_back #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.stat     (bk_stat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.pop |-> q_valid)
		else $error("Back end popped an empty queue.");

	a_no_report_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !bk_stat.load)
		else $error("Report loaded over a transaction still waiting.");

	a_load_shows_report: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.load |=> out_valid)
		else $error("Loaded report did not appear at the output.");

endmodule

@@ rtl/core/pear_front.sv @@
module pear_front #(
	parameter int NUM_BUTTONS = pear_pkg::NUM_BUTTONS_DEF
) (
	input  pear_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  pear_pkg::in_item_t in_data,
	input  logic               q_full,
	output logic               push,
	output pear_pkg::q_entry_t entry
);

	logic [pear_pkg::CODE_W-1:0] code;
	logic is_neg;
	logic inv;
	logic [pear_pkg::VAL_W-1:0] mag;

	assign in_stall = q_full;
	assign push = in_valid && !q_full;

	always_comb begin
		code = in_data.event_code;
		if (in_data.from_device && cfg.swap_axes) begin
			if (code == pear_pkg::CODE_X) begin
				code = pear_pkg::CODE_Y;
			end else if (code == pear_pkg::CODE_Y) begin
				code = pear_pkg::CODE_X;
			end
		end

		is_neg = in_data.event_value[pear_pkg::VAL_W-1];
		inv = in_data.from_device && (in_data.event_kind == pear_pkg::KIND_REL) &&
			((cfg.invert_x && code == pear_pkg::CODE_X) ||
			 (cfg.invert_y && code == pear_pkg::CODE_Y));
		mag = is_neg ? pear_pkg::VAL_W'(~in_data.event_value + 1'b1) :
			pear_pkg::VAL_W'(in_data.event_value);

		entry.dest = pear_pkg::DEST_NONE;
		entry.btn_idx = code[pear_pkg::BTN_IDX_W-1:0];
		entry.sync = in_data.sync_mark;
		entry.dev = in_data.from_device;
		entry.neg = in_data.from_device && (is_neg ^ inv);
		entry.value = in_data.from_device ? mag : pear_pkg::VAL_W'(in_data.event_value);

		case (in_data.event_kind)
			pear_pkg::KIND_REL: begin
				unique case (code)
					pear_pkg::CODE_X: entry.dest = pear_pkg::DEST_X;
					pear_pkg::CODE_Y: entry.dest = pear_pkg::DEST_Y;
					pear_pkg::CODE_HWHEEL: entry.dest = pear_pkg::DEST_HWHEEL;
					pear_pkg::CODE_WHEEL: entry.dest = pear_pkg::DEST_WHEEL;
					default: entry.dest = pear_pkg::DEST_NONE;
				endcase
			end
			pear_pkg::KIND_KEY: begin
				if (code[pear_pkg::CODE_W-1:8] == pear_pkg::CODE_BTN_PAGE &&
					code[7:0] < 8'(NUM_BUTTONS)) begin
					entry.dest = pear_pkg::DEST_BUTTON;
				end
			end
			default: entry.dest = pear_pkg::DEST_NONE;
		endcase
	end

endmodule

@@ rtl/core/pear_queue.sv @@
module pear_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pear_pkg::q_entry_t entry_in,
	output logic               full,
	input  logic               pop,
	output logic               valid,
	output pear_pkg::q_entry_t entry_out
);

	localparam int Depth = 2;

	pear_pkg::q_entry_t mem_q [Depth];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'(Depth));
	assign valid = (count_q != 2'd0);
	assign entry_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry_in;
		end
	end

endmodule

@@ rtl/core/pear_back.sv @@
module pear_back #(
	parameter int NUM_BUTTONS = pear_pkg::NUM_BUTTONS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pear_pkg::cfg_t      cfg,
	input  logic                q_valid,
	input  pear_pkg::q_entry_t  q_entry,
	output pear_pkg::bk_stat_t  stat,
	output logic                out_valid,
	input  logic                out_stall,
	output pear_pkg::out_item_t out_data
);

	localparam int VW = pear_pkg::VAL_W;
	localparam int DivCycles = VW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_APPLY
	} state_t;

	state_t state_q;
	pear_pkg::q_entry_t ent_q;
	logic [2*VW-1:0] dq_q;
	logic [VW-1:0] rem_q;
	logic [3:0] cnt_q;
	logic [VW-1:0] mx_q, my_q, wx_q, wy_q;
	logic [NUM_BUTTONS-1:0] press_q, release_q, bs_q;
	logic out_valid_q;
	pear_pkg::out_item_t out_q;

	logic [VW-1:0] d_eff;
	logic [2*VW-1:0] prod;
	logic [3*VW-1:0] step1, step2;
	logic [VW-1:0] v;
	logic v_pos;
	logic [NUM_BUTTONS-1:0] btn_mask;
	logic [VW-1:0] mx_n, my_n, wx_n, wy_n;
	logic [NUM_BUTTONS-1:0] press_n, release_n, bs_n;
	logic [NUM_BUTTONS+pear_pkg::HELD_W-1:0] held_ext;
	logic finish;

	function automatic logic [3*VW-1:0] div_step(
		input logic [VW-1:0] rem,
		input logic [2*VW-1:0] dq,
		input logic [VW-1:0] d
	);
		logic [VW:0] r;
		logic ge;
		logic [VW-1:0] rn;
		r = {rem, dq[2*VW-1]};
		ge = (r >= {1'b0, d});
		rn = ge ? VW'(r - {1'b0, d}) : r[VW-1:0];
		return {rn, dq[2*VW-2:0], ge};
	endfunction

	assign d_eff = (cfg.scale_div == '0) ? VW'(1) : cfg.scale_div;
	assign prod = ent_q.value * cfg.scale_mul;
	assign step1 = div_step(rem_q, dq_q, d_eff);
	assign step2 = div_step(step1[3*VW-1:2*VW], step1[2*VW-1:0], d_eff);

	always_comb begin
		v = ent_q.neg ? VW'(~dq_q[VW-1:0] + 1'b1) : dq_q[VW-1:0];
		v_pos = !v[VW-1] && (v != '0);
		btn_mask = NUM_BUTTONS'(1) << ent_q.btn_idx;
		mx_n = mx_q;
		my_n = my_q;
		wx_n = wx_q;
		wy_n = wy_q;
		press_n = press_q;
		release_n = release_q;
		case (ent_q.dest)
			pear_pkg::DEST_X: mx_n = mx_q + v;
			pear_pkg::DEST_Y: my_n = my_q + v;
			pear_pkg::DEST_HWHEEL: wx_n = wx_q + v;
			pear_pkg::DEST_WHEEL: wy_n = wy_q + v;
			pear_pkg::DEST_BUTTON: begin
				if (v_pos) begin
					press_n = press_q | btn_mask;
				end else begin
					release_n = release_q | btn_mask;
				end
			end
			default: ;
		endcase
		bs_n = (bs_q | press_n) & ~release_n;
		held_ext = {{pear_pkg::HELD_W{1'b0}}, bs_n};
		finish = (state_q == ST_APPLY) && (!ent_q.sync || !out_valid_q || !out_stall);
	end

	assign stat.pop = (state_q == ST_IDLE) && q_valid;
	assign stat.load = finish && ent_q.sync;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ent_q <= '0;
			dq_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			mx_q <= '0;
			my_q <= '0;
			wx_q <= '0;
			wy_q <= '0;
			press_q <= '0;
			release_q <= '0;
			bs_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && !stat.load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						ent_q <= q_entry;
						dq_q <= {{VW{1'b0}}, q_entry.value};
						state_q <= q_entry.dev ? ST_MUL : ST_APPLY;
					end
				end
				ST_MUL: begin
					dq_q <= prod;
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= step2[3*VW-1:2*VW];
					dq_q <= step2[2*VW-1:0];
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'(DivCycles - 1)) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (ent_q.sync) begin
							mx_q <= '0;
							my_q <= '0;
							wx_q <= '0;
							wy_q <= '0;
							press_q <= '0;
							release_q <= '0;
							bs_q <= bs_n;
							out_valid_q <= 1'b1;
							out_q.move_x <= mx_n;
							out_q.move_y <= my_n;
							out_q.scroll_x <= wx_n;
							out_q.scroll_y <= wy_n;
							out_q.held_buttons <= held_ext[pear_pkg::HELD_W-1:0];
						end else begin
							mx_q <= mx_n;
							my_q <= my_n;
							wx_q <= wx_n;
							wy_q <= wy_n;
							press_q <= press_n;
							release_q <= release_n;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import pear_pkg::*;

	localparam logic [1:0] KIND_ABS = 2'd1;
	localparam logic [1:0] KIND_OTHER = 2'd3;
	localparam logic [CODE_W-1:0] BTN_BASE = 10'd256;
	localparam int SETTLE_CYCLES = 80;
	localparam int ITEM_TARGET = 1050;

	class report_tracker;
		cfg_t cfg;
		logic [VAL_W-1:0] sum_x, sum_y, wheel_x, wheel_y;
		logic [HELD_W-1:0] pressed, released, held;
		out_item_t expected_reports[$];
		int errors;

		function new();
			cfg = '0;
			cfg.scale_mul = VAL_W'(1);
			cfg.scale_div = VAL_W'(1);
			sum_x = '0;
			sum_y = '0;
			wheel_x = '0;
			wheel_y = '0;
			pressed = '0;
			released = '0;
			held = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_SWAP_AXES: cfg.swap_axes = val[0];
				REG_INVERT_X: cfg.invert_x = val[0];
				REG_INVERT_Y: cfg.invert_y = val[0];
				REG_SCALE_MUL: cfg.scale_mul = val[VAL_W-1:0];
				REG_SCALE_DIV: cfg.scale_div = val[VAL_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		function void note_event(in_item_t ev);
			logic [CODE_W-1:0] code;
			longint v, q, d;
			logic [VAL_W-1:0] v16;
			logic [HELD_W-1:0] btn_mask;
			out_item_t rep;
			code = ev.event_code;
			v = longint'($signed(ev.event_value));
			if (ev.from_device) begin
				d = (cfg.scale_div == 0) ? 1 : longint'(cfg.scale_div);
				if (cfg.swap_axes) begin
					if (code == CODE_X)
						code = CODE_Y;
					else if (code == CODE_Y)
						code = CODE_X;
				end
				if (ev.event_kind == KIND_REL &&
						((cfg.invert_x && code == CODE_X) || (cfg.invert_y && code == CODE_Y)))
					v = -v;
				q = (v * longint'(cfg.scale_mul)) / d;
				v = longint'($signed(q[VAL_W-1:0]));
			end
			v16 = v[VAL_W-1:0];
			if (ev.event_kind == KIND_REL) begin
				if (code == CODE_X)
					sum_x = sum_x + v16;
				else if (code == CODE_Y)
					sum_y = sum_y + v16;
				else if (code == CODE_WHEEL)
					wheel_y = wheel_y + v16;
				else if (code == CODE_HWHEEL)
					wheel_x = wheel_x + v16;
			end else if (ev.event_kind == KIND_KEY) begin
				if (code >= BTN_BASE && code < BTN_BASE + NUM_BUTTONS_DEF) begin
					btn_mask = HELD_W'(1) << (code - BTN_BASE);
					if (v > 0)
						pressed = pressed | btn_mask;
					else
						released = released | btn_mask;
				end
			end
			if (ev.sync_mark) begin
				held = (held | pressed) & ~released;
				rep.move_x = sum_x;
				rep.move_y = sum_y;
				rep.scroll_x = wheel_x;
				rep.scroll_y = wheel_y;
				rep.held_buttons = held;
				expected_reports.push_back(rep);
				sum_x = '0;
				sum_y = '0;
				wheel_x = '0;
				wheel_y = '0;
				pressed = '0;
				released = '0;
			end
		endfunction

		function void check_report(out_item_t got);
			out_item_t exp_rep;
			if (expected_reports.size() == 0) begin
				$error("unexpected report: move_x %0d move_y %0d held %b",
					got.move_x, got.move_y, got.held_buttons);
				errors++;
				return;
			end
			exp_rep = expected_reports.pop_front();
			if (got.move_x !== exp_rep.move_x) begin
				$error("move_x: expected %0d, got %0d", exp_rep.move_x, got.move_x);
				errors++;
			end
			if (got.move_y !== exp_rep.move_y) begin
				$error("move_y: expected %0d, got %0d", exp_rep.move_y, got.move_y);
				errors++;
			end
			if (got.scroll_x !== exp_rep.scroll_x) begin
				$error("scroll_x: expected %0d, got %0d", exp_rep.scroll_x, got.scroll_x);
				errors++;
			end
			if (got.scroll_y !== exp_rep.scroll_y) begin
				$error("scroll_y: expected %0d, got %0d", exp_rep.scroll_y, got.scroll_y);
				errors++;
			end
			if (got.held_buttons !== exp_rep.held_buttons) begin
				$error("held_buttons: expected %b, got %b",
					exp_rep.held_buttons, got.held_buttons);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	report_tracker tracker = new();
	int sent_items;
	int quiet_items;

	pointer_event_report_aggregator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return VAL_W'($urandom_range(0, 40) - 20);
			4, 5, 6: return VAL_W'($urandom);
			7: return 16'h8000;
			8: return 16'h7FFF;
			default: return VAL_W'($urandom_range(0, 2) - 1);
		endcase
	endfunction

	function automatic in_item_t pick_event(logic sync, logic noisy);
		in_item_t ev;
		int r;
		ev.sync_mark = sync;
		ev.event_value = pick_value();
		ev.from_device = ($urandom_range(0, 9) < 7);
		if (noisy) begin
			ev.event_kind = 2'($urandom);
			ev.event_code = CODE_W'($urandom);
			return ev;
		end
		r = $urandom_range(0, 9);
		if (r < 5)
			ev.event_kind = KIND_REL;
		else if (r < 8)
			ev.event_kind = KIND_KEY;
		else if (r < 9)
			ev.event_kind = KIND_ABS;
		else
			ev.event_kind = KIND_OTHER;
		if (ev.event_kind == KIND_KEY) begin
			if ($urandom_range(0, 9) < 8)
				ev.event_code = BTN_BASE + CODE_W'($urandom_range(0, 7));
			else
				ev.event_code = CODE_W'($urandom);
		end else begin
			case ($urandom_range(0, 6))
				0: ev.event_code = CODE_X;
				1: ev.event_code = CODE_Y;
				2: ev.event_code = CODE_HWHEEL;
				3: ev.event_code = CODE_WHEEL;
				4: ev.event_code = CODE_X;
				5: ev.event_code = CODE_Y;
				default: ev.event_code = CODE_W'($urandom);
			endcase
		end
		return ev;
	endfunction

	task automatic drive_event(in_item_t ev);
		int gap;
		gap = (quiet_items > 0) ? 0 : pick_gap();
		if (quiet_items > 0)
			quiet_items--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= ev;
		do @(posedge clk); while (in_stall !== 1'b0);
		tracker.note_event(ev);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic post_event(logic [1:0] kind, logic [CODE_W-1:0] code, int value,
			logic sync, logic dev);
		in_item_t ev;
		ev.event_kind = kind;
		ev.event_code = code;
		ev.event_value = VAL_W'(value);
		ev.sync_mark = sync;
		ev.from_device = dev;
		drive_event(ev);
	endtask

	task automatic wait_reports();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		wait_reports();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(logic [2:0] idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		tracker.set_reg(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_config(logic swap, logic inv_x, logic inv_y,
			logic [VAL_W-1:0] mul, logic [VAL_W-1:0] div);
		settle();
		apb_write(REG_SWAP_AXES, DATA_W'(swap));
		apb_write(REG_INVERT_X, DATA_W'(inv_x));
		apb_write(REG_INVERT_Y, DATA_W'(inv_y));
		apb_write(REG_SCALE_MUL, DATA_W'(mul));
		apb_write(REG_SCALE_DIV, DATA_W'(div));
	endtask

	function automatic logic [VAL_W-1:0] pick_scale();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return VAL_W'(1);
			2: return 16'hFFFF;
			3, 4: return VAL_W'($urandom_range(1, 8));
			default: return VAL_W'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			tracker.check_report(out_data);
	end

	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			if ($urandom_range(0, 19) == 0)
				repeat ($urandom_range(50, 200)) @(negedge clk);
			else
				repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	end

	initial begin
		#10ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int phase_target;
		int frame;
		int len;
		logic noisy;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sent_items = 0;
		quiet_items = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Default settings: wrap, buttons, ignored kinds and codes.
		post_event(KIND_REL, CODE_X, 32767, 1'b0, 1'b1);
		post_event(KIND_REL, CODE_X, 1, 1'b0, 1'b1);
		post_event(KIND_REL, CODE_Y, -32768, 1'b1, 1'b0);
		post_event(KIND_REL, CODE_HWHEEL, 5, 1'b0, 1'b1);
		post_event(KIND_REL, CODE_WHEEL, -7, 1'b1, 1'b1);
		post_event(KIND_KEY, BTN_BASE, 1, 1'b0, 1'b1);
		post_event(KIND_KEY, BTN_BASE + 10'd4, 32767, 1'b0, 1'b0);
		post_event(KIND_KEY, BTN_BASE + 10'd1, 0, 1'b0, 1'b1);
		post_event(KIND_OTHER, 10'd1023, -1, 1'b1, 1'b1);
		// A button pressed and released in one frame ends released.
		post_event(KIND_KEY, BTN_BASE, 5, 1'b0, 1'b1);
		post_event(KIND_KEY, BTN_BASE, -5, 1'b0, 1'b1);
		post_event(KIND_KEY, BTN_BASE + 10'd2, 1, 1'b1, 1'b1);
		post_event(KIND_ABS, CODE_X, 100, 1'b0, 1'b1);
		post_event(KIND_REL, 10'd2, 50, 1'b0, 1'b1);
		post_event(KIND_KEY, BTN_BASE + 10'd5, 1, 1'b0, 1'b1);
		post_event(KIND_KEY, 10'd255, 1, 1'b0, 1'b1);
		post_event(KIND_REL, 10'd1023, 9, 1'b1, 1'b1);
		post_event(KIND_OTHER, CODE_X, 0, 1'b1, 1'b0);

		// Swap with a zero divisor, which acts as one.
		apply_config(1'b1, 1'b1, 1'b0, 16'd3, 16'd0);
		post_event(KIND_REL, CODE_X, 10, 1'b0, 1'b1);
		post_event(KIND_REL, CODE_Y, -32768, 1'b1, 1'b1);
		post_event(KIND_KEY, CODE_X, 1, 1'b0, 1'b1);
		post_event(KIND_KEY, BTN_BASE + 10'd1, -1, 1'b0, 1'b1);
		post_event(KIND_REL, CODE_X, 7, 1'b1, 1'b0);

		// A zero multiplier turns a device key press into a release.
		apply_config(1'b0, 1'b1, 1'b1, 16'd0, 16'hFFFF);
		post_event(KIND_KEY, BTN_BASE + 10'd3, 100, 1'b0, 1'b1);
		post_event(KIND_KEY, BTN_BASE + 10'd3, 1, 1'b0, 1'b0);
		post_event(KIND_REL, CODE_X, -32768, 1'b1, 1'b1);

		apply_config(1'b0, 1'b1, 1'b1, 16'hFFFF, 16'd1);
		post_event(KIND_REL, CODE_X, -32768, 1'b0, 1'b1);
		post_event(KIND_REL, CODE_WHEEL, 32767, 1'b1, 1'b1);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: apply_config(1'b0, 1'b0, 1'b0, 16'd1, 16'd1);
				1: apply_config(1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
				2: apply_config(1'($urandom), 1'($urandom), 1'($urandom), 16'd0, 16'd1);
				default: apply_config(1'($urandom), 1'($urandom), 1'($urandom),
					pick_scale(), pick_scale());
			endcase
			phase_target = 30 + (p + 1) * (ITEM_TARGET / 6);
			frame = 0;
			while (sent_items < phase_target) begin
				if ($urandom_range(0, 9) == 0)
					quiet_items = $urandom_range(10, 40);
				noisy = ($urandom_range(0, 99) < 15);
				len = $urandom_range(0, 7);
				for (int k = 0; k < len; k++)
					drive_event(pick_event(noisy && ($urandom_range(0, 3) == 0), noisy));
				drive_event(pick_event(1'b1, noisy && ($urandom_range(0, 1) == 0)));
				frame++;
				if (frame == 12)
					wait_reports();
			end
		end

		wait_reports();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/pear_pkg.sv
rtl/core/pear_front.sv
rtl/core/pear_queue.sv
rtl/core/pear_back.sv
rtl/core/pointer_event_report_aggregator_unit.sv
bench/tb_top.sv
